### rtl/multi_channel_heartbeat_monitor_unit_defines.svh
// Assertion macros shared by the heartbeat monitor RTL.
// Needs clk and rst in scope at the point of use.
`ifndef MULTI_CHANNEL_HEARTBEAT_MONITOR_UNIT_DEFINES_SVH
`define MULTI_CHANNEL_HEARTBEAT_MONITOR_UNIT_DEFINES_SVH

// same-cycle implication
`define MCHM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MCHM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/mchm_pkg.sv
// Shared types, constants and loop-index helpers for the heartbeat monitor.
// No dependencies.
package mchm_pkg;

  localparam int MOTORS_DEF    = 8;
  localparam int TICK_BITS_DEF = 32;
  localparam int LOOPS         = 12;
  localparam int WAIT_W        = 32;
  localparam logic [WAIT_W-1:0] WAIT_RESET = 32'd100;

  typedef enum logic [1:0] {
    EV_MSG_OK  = 2'd0,
    EV_OFFLINE = 2'd1,
    EV_DONE    = 2'd2,
    EV_RANGE   = 2'd3
  } event_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MSG,
    ST_SCAN,
    ST_FIN
  } state_t;

  // speed loop index: motors 4 and 5 trade places
  function automatic logic [2:0] speed_index(input logic [2:0] m);
    logic [2:0] r;
    r = m;
    if (m == 3'd4) r = 3'd5;
    if (m == 3'd5) r = 3'd4;
    return r;
  endfunction

  function automatic logic has_pos(input logic [2:0] idx);
    return idx[2];
  endfunction

  // speed bit plus, for indices 4..7, the position bit at index + 4
  function automatic logic [LOOPS-1:0] loop_bits(input logic [2:0] idx);
    logic [LOOPS-1:0] v;
    v = '0;
    v[idx] = 1'b1;
    if (idx[2]) v[{2'b10, idx[1:0]}] = 1'b1;
    return v;
  endfunction

endpackage

### rtl/multi_channel_heartbeat_monitor_unit.sv
// Per-motor heartbeat timeout monitor, top level.
// Uses mchm_pkg, mchm_elapsed_cmp and the assertion macro header.
//
// Usage:
//   s_* channel takes one word per command: tuser = opcode (0 message,
//   1 sweep), tdata = motor and current tick. m_* channel returns result
//   words: tuser = event code, tlast marks the final result of a command.
//   cfg_* writes the timeout in ticks; it is always ready.
// Operation:
//   A message gives one result, loaded into the output register from the
//   message state once that register is free. A sweep visits one motor per
//   cycle, unless it halts on an output stall (see Stall), through the single
//   elapsed-time subtract/compare unit; each dropped motor yields one word,
//   or one done word when none drops. s_tready is high only while no command
//   is in work.
// Stall:
//   A single output register holds a result until m_tready; the sweep halts
//   on a motor that drops while an earlier result still waits for a free
//   output register. The next command may be accepted while the final result
//   of the previous one is still held.
// Reset:
//   rst (synchronous) marks all motors offline, clears all loop enables,
//   sets the timeout to 100 ticks and empties the output register.
`include "multi_channel_heartbeat_monitor_unit_defines.svh"

module multi_channel_heartbeat_monitor_unit #(
  parameter int MOTORS    = mchm_pkg::MOTORS_DEF,
  parameter int TICK_BITS = mchm_pkg::TICK_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [3:0] motor, [35:4] now, [39:36] zero
  input  logic        s_tuser,   // [0] opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [3:0] event_motor, [6:4] speed_loop_index,
                                 // [7] has_position_loop, [19:8] loop_enable_mask,
                                 // [20] first_motor_online, [23:21] zero
  output logic [1:0]  m_tuser,   // [1:0] event_res
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  localparam int IDX_W = $clog2(MOTORS);
  localparam int LOOPS = mchm_pkg::LOOPS;

  mchm_pkg::state_t state, state_next;

  logic [mchm_pkg::WAIT_W-1:0] wait_ticks;
  logic [MOTORS-1:0]           online;
  logic [LOOPS-1:0]            loop_en;
  logic [TICK_BITS-1:0]        seen_mem [MOTORS];

  logic [3:0]           in_motor;
  logic [TICK_BITS-1:0] in_now;
  logic [IDX_W-1:0]     cnt;

  logic             pend_valid;
  logic [3:0]       pend_motor;
  logic [2:0]       pend_idx;
  logic             pend_pos;
  logic [LOOPS-1:0] pend_mask;

  // control and output-load decisions
  logic             slot_free;
  logic             out_load;
  logic [1:0]       out_ev;
  logic [3:0]       out_motor;
  logic [2:0]       out_idx;
  logic             out_pos;
  logic [LOOPS-1:0] out_mask;
  logic             out_first;
  logic             out_last;
  logic             do_msg;
  logic             do_drop;
  logic             cnt_adv;
  logic             pend_clr;

  logic             in_range;
  logic [2:0]       msg_idx;
  logic [2:0]       scan_idx;
  logic [LOOPS-1:0] scan_mask;
  logic             over;
  logic             drop;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == mchm_pkg::ST_IDLE);
  assign slot_free = !m_tvalid || m_tready;

  assign in_range  = in_motor < 4'(MOTORS);
  assign msg_idx   = mchm_pkg::speed_index(in_motor[2:0]);
  assign scan_idx  = mchm_pkg::speed_index(3'(cnt));
  assign scan_mask = loop_en & ~mchm_pkg::loop_bits(scan_idx);

  mchm_elapsed_cmp #(
    .TICK_BITS (TICK_BITS)
  ) u_cmp (
    .now        (in_now),
    .seen       (seen_mem[cnt]),
    .wait_ticks (wait_ticks),
    .over       (over)
  );

  assign drop = online[cnt] && over;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mchm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    out_ev     = mchm_pkg::EV_MSG_OK;
    out_motor  = '0;
    out_idx    = '0;
    out_pos    = 1'b0;
    out_mask   = loop_en;
    out_first  = online[0];
    out_last   = 1'b1;
    do_msg     = 1'b0;
    do_drop    = 1'b0;
    cnt_adv    = 1'b0;
    pend_clr   = 1'b0;
    unique case (state)
      mchm_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = s_tuser ? mchm_pkg::ST_SCAN : mchm_pkg::ST_MSG;
        end
      end
      mchm_pkg::ST_MSG: begin
        if (slot_free) begin
          out_load   = 1'b1;
          out_motor  = in_motor;
          state_next = mchm_pkg::ST_IDLE;
          if (in_range) begin
            do_msg    = 1'b1;
            out_ev    = mchm_pkg::EV_MSG_OK;
            out_idx   = msg_idx;
            out_pos   = mchm_pkg::has_pos(msg_idx);
            out_mask  = loop_en | mchm_pkg::loop_bits(msg_idx);
            out_first = online[0] || (in_motor == 4'd0);
          end else begin
            out_ev = mchm_pkg::EV_RANGE;
          end
        end
      end
      mchm_pkg::ST_SCAN: begin
        // hold while a drop needs to push out the previous one
        if (!(drop && pend_valid && !slot_free)) begin
          cnt_adv = 1'b1;
          if (drop) begin
            do_drop = 1'b1;
            if (pend_valid) begin
              out_load  = 1'b1;
              out_ev    = mchm_pkg::EV_OFFLINE;
              out_motor = pend_motor;
              out_idx   = pend_idx;
              out_pos   = pend_pos;
              out_mask  = pend_mask;
              out_first = online[0];
              out_last  = 1'b0;
            end
          end
          if (cnt == IDX_W'(MOTORS - 1)) begin
            state_next = mchm_pkg::ST_FIN;
          end
        end
      end
      mchm_pkg::ST_FIN: begin
        if (slot_free) begin
          out_load   = 1'b1;
          pend_clr   = 1'b1;
          state_next = mchm_pkg::ST_IDLE;
          if (pend_valid) begin
            out_ev    = mchm_pkg::EV_OFFLINE;
            out_motor = pend_motor;
            out_idx   = pend_idx;
            out_pos   = pend_pos;
            out_mask  = pend_mask;
          end else begin
            out_ev = mchm_pkg::EV_DONE;
          end
        end
      end
      default: state_next = mchm_pkg::ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      wait_ticks <= mchm_pkg::WAIT_RESET;
      online     <= '0;
      loop_en    <= '0;
      m_tvalid   <= 1'b0;
      pend_valid <= 1'b0;
      cnt        <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        wait_ticks <= cfg_data;
      end
      if (s_tvalid && s_tready) begin
        cnt <= '0;
      end else if (cnt_adv && cnt != IDX_W'(MOTORS - 1)) begin
        cnt <= cnt + 1'b1;
      end
      if (do_msg) begin
        online[in_motor[IDX_W-1:0]] <= 1'b1;
        loop_en <= loop_en | mchm_pkg::loop_bits(msg_idx);
      end
      if (do_drop) begin
        online[cnt] <= 1'b0;
        loop_en     <= scan_mask;
        pend_valid  <= 1'b1;
      end else if (pend_clr) begin
        pend_valid <= 1'b0;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_motor <= s_tdata[3:0];
      in_now   <= TICK_BITS'(s_tdata[35:4]);
    end
    if (do_msg) begin
      seen_mem[in_motor[IDX_W-1:0]] <= in_now;
    end
    if (do_drop) begin
      pend_motor <= 4'(cnt);
      pend_idx   <= scan_idx;
      pend_pos   <= mchm_pkg::has_pos(scan_idx);
      pend_mask  <= scan_mask;
    end
    if (out_load) begin
      m_tuser <= out_ev;
      m_tlast <= out_last;
      m_tdata <= {3'b000, out_first, out_mask, out_pos, out_idx, out_motor};
    end
  end

  `MCHM_ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready,
                    state != mchm_pkg::ST_IDLE, "accept left block idle")
  `MCHM_ASSERT_NOW(a_done_last, m_tvalid && (m_tuser == mchm_pkg::EV_DONE),
                   m_tlast, "done result without last")
  `MCHM_ASSERT_NOW(a_drop_motor, m_tvalid && (m_tuser == mchm_pkg::EV_OFFLINE),
                   m_tdata[3:0] < 4'(MOTORS), "offline motor out of range")
  `MCHM_ASSERT_NOW(a_range_motor, m_tvalid && (m_tuser == mchm_pkg::EV_RANGE),
                   m_tdata[3:0] >= 4'(MOTORS), "range event for valid motor")

endmodule

### rtl/mchm_elapsed_cmp.sv
// Shared elapsed-time unit: wrapped subtract of a stored tick from now,
// compared against the timeout. Uses mchm_pkg.
module mchm_elapsed_cmp #(
  parameter int TICK_BITS = mchm_pkg::TICK_BITS_DEF
) (
  input  logic [TICK_BITS-1:0]          now,
  input  logic [TICK_BITS-1:0]          seen,
  input  logic [mchm_pkg::WAIT_W-1:0]   wait_ticks,
  output logic                          over
);

  localparam int CW = (TICK_BITS > mchm_pkg::WAIT_W) ? TICK_BITS : mchm_pkg::WAIT_W;

  logic [TICK_BITS-1:0] elapsed;

  assign elapsed = now - seen;
  assign over    = CW'(elapsed) > CW'(wait_ticks);

endmodule
